// ===== sv/i2cm_pkg.sv =====
package i2cm_pkg;

   // operation codes carried in a request beat
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_STOP  = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   // register indexes of the CSR port
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_LOW_TICKS  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_HIGH_TICKS = 1'b1;
   localparam int unsigned CSR_DATA_W = 16;
   localparam logic [CSR_DATA_W-1:0] RESET_TICKS = 16'd10;

   // bit counts for the byte loops
   localparam logic [3:0] WRITE_CLOCKS = 4'd9;
   localparam logic [3:0] READ_BITS    = 4'd8;

   // depth of the two small queues
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_START,
      CMD_STOP,
      CMD_WRITE,
      CMD_READ
   } cmd_type;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_S1,
      PH_S2,
      PH_S3,
      PH_P1,
      PH_P2,
      PH_P3,
      PH_W1,
      PH_W2,
      PH_W3,
      PH_R1,
      PH_R2,
      PH_A1,
      PH_A2,
      PH_A3
   } phase_type;

   typedef struct packed {
      logic [2:0] operation;
      logic       start_read;
      logic [7:0] write_byte;
      logic       send_ack;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic [7:0] read_byte;
      logic       read_valid;
   } rsp_type;

   // decoded tick as it travels from the front to the engine
   typedef struct packed {
      cmd_type    cmd;
      logic       start_read;
      logic [7:0] write_byte;
      logic       send_ack;
      logic       sda_in;
   } tick_type;

endpackage

// ===== sv/i2c_master_bit_engine_core.sv =====
// A pushed tick beat waits in the front queue; its result beat waits in the result queue.
// Throughput: one tick beat per cycle while the result queue has room to take its result.
// Two-entry queues on each side let the push and pop sides stall on their own.
// Reset (synchronous, active high): engine idle, SCL and SDA driven high,
// timing registers at 10 ticks, read byte 0, both queues empty.
module i2c_master_bit_engine_core #(
   parameter int unsigned TIMER_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  i2cm_pkg::req_type                req_item,
   output logic                             empty,
   input  logic                             pop,
   output i2cm_pkg::rsp_type                rsp_item,
   input  logic                             csr_write_en,
   input  logic [i2cm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [i2cm_pkg::CSR_DATA_W-1:0]  csr_data
);

   // decoded tick between the front and the engine
   logic               tick_valid;
   i2cm_pkg::tick_type tick_item;
   logic               tick_take;

   // result beat between the engine and the output queue
   logic              rsp_push;
   logic              rsp_full;
   i2cm_pkg::rsp_type rsp_beat;

   // front: decode operation codes and buffer tick beats
   i2cm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_item   (req_item),
      .tick_valid (tick_valid),
      .tick_item  (tick_item),
      .tick_take  (tick_take)
   );

   // back: bit timing state machine, steps one tick per accepted beat
   i2cm_engine #(
      .TIMER_BITS (TIMER_BITS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .tick_valid   (tick_valid),
      .tick_item    (tick_item),
      .tick_take    (tick_take),
      .rsp_full     (rsp_full),
      .rsp_push     (rsp_push),
      .rsp_beat     (rsp_beat)
   );

   // hold finished results until the consumer pops them
   i2cm_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .rsp_push (rsp_push),
      .rsp_beat (rsp_beat),
      .rsp_full (rsp_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule

// ===== sv/i2cm_front.sv =====
module i2cm_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  i2cm_pkg::req_type  req_item,
   output logic               tick_valid,
   output i2cm_pkg::tick_type tick_item,
   input  logic               tick_take
);

   i2cm_pkg::tick_type decoded;
   i2cm_pkg::tick_type slot_ff [i2cm_pkg::QUEUE_DEPTH];
   logic [i2cm_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [i2cm_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [i2cm_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   // classify the operation; unknown codes act as no command
   always_comb begin
      decoded.start_read = req_item.start_read;
      decoded.write_byte = req_item.write_byte;
      decoded.send_ack   = req_item.send_ack;
      decoded.sda_in     = req_item.sda_in;
      case (req_item.operation)
         i2cm_pkg::OP_START: decoded.cmd = i2cm_pkg::CMD_START;
         i2cm_pkg::OP_STOP:  decoded.cmd = i2cm_pkg::CMD_STOP;
         i2cm_pkg::OP_WRITE: decoded.cmd = i2cm_pkg::CMD_WRITE;
         i2cm_pkg::OP_READ:  decoded.cmd = i2cm_pkg::CMD_READ;
         default:            decoded.cmd = i2cm_pkg::CMD_NONE;
      endcase
   end

   assign full       = (count_ff == i2cm_pkg::QCNT_W'(i2cm_pkg::QUEUE_DEPTH));
   assign tick_valid = (count_ff != '0);
   assign tick_item  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = tick_take && tick_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ===== sv/i2cm_engine.sv =====
module i2cm_engine #(
   parameter int unsigned TIMER_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [i2cm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [i2cm_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                tick_valid,
   input  i2cm_pkg::tick_type                  tick_item,
   output logic                                tick_take,
   input  logic                                rsp_full,
   output logic                                rsp_push,
   output i2cm_pkg::rsp_type                   rsp_beat
);

   logic [i2cm_pkg::CSR_DATA_W-1:0] low_ff, high_ff;

   i2cm_pkg::phase_type phase_ff, phase_in;
   logic [TIMER_BITS-1:0] wait_ff, wait_in;
   logic [3:0] bit_ff, bit_in, bit_next;
   logic [7:0] shift_ff, shift_in;
   logic       addr_pend_ff, addr_pend_in;
   logic       read_flag_ff, read_flag_in;
   logic       scl_ff, scl_in;
   logic       sda_lvl_ff, sda_lvl_in;
   logic       drive_ff, drive_in;
   logic [7:0] held_ff, held_in;
   logic       valid_in;

   logic [TIMER_BITS-1:0] low_wait, high_wait, half_wait;
   logic at_idle;
   logic counting;
   logic step;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= i2cm_pkg::RESET_TICKS;
         high_ff <= i2cm_pkg::RESET_TICKS;
      end else if (csr_write_en) begin
         case (csr_index)
            i2cm_pkg::REG_LOW_TICKS:  low_ff  <= csr_data;
            i2cm_pkg::REG_HIGH_TICKS: high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign low_wait  = TIMER_BITS'(low_ff);
   assign high_wait = TIMER_BITS'(high_ff);
   assign half_wait = TIMER_BITS'(low_ff >> 1);

   assign at_idle  = (phase_ff == i2cm_pkg::PH_IDLE);
   assign counting = (wait_ff > TIMER_BITS'(1));
   assign bit_next = bit_ff + 4'd1;

   // advance one tick whenever a tick is queued and the result has room
   assign step      = tick_valid && !rsp_full;
   assign tick_take = step;
   assign rsp_push  = step;

   // next state and wait load
   always_comb begin
      phase_in = phase_ff;
      wait_in  = wait_ff;
      if (at_idle) begin
         case (tick_item.cmd)
            i2cm_pkg::CMD_START: begin
               phase_in = i2cm_pkg::PH_S1;
               wait_in  = low_wait;
            end
            i2cm_pkg::CMD_STOP: begin
               phase_in = i2cm_pkg::PH_P1;
               wait_in  = half_wait;
            end
            i2cm_pkg::CMD_WRITE: begin
               phase_in = i2cm_pkg::PH_W1;
               wait_in  = half_wait;
            end
            i2cm_pkg::CMD_READ: begin
               phase_in = i2cm_pkg::PH_R1;
               wait_in  = low_wait;
            end
            default: ;
         endcase
      end else if (counting) begin
         wait_in = wait_ff - TIMER_BITS'(1);
      end else begin
         wait_in = '0;
         case (phase_ff)
            i2cm_pkg::PH_S1: begin phase_in = i2cm_pkg::PH_S2; wait_in = high_wait; end
            i2cm_pkg::PH_S2: begin phase_in = i2cm_pkg::PH_S3; wait_in = high_wait; end
            i2cm_pkg::PH_P1: begin phase_in = i2cm_pkg::PH_P2; wait_in = half_wait; end
            i2cm_pkg::PH_P2: begin phase_in = i2cm_pkg::PH_P3; wait_in = high_wait; end
            i2cm_pkg::PH_W1: begin phase_in = i2cm_pkg::PH_W2; wait_in = half_wait; end
            i2cm_pkg::PH_W2: begin phase_in = i2cm_pkg::PH_W3; wait_in = high_wait; end
            i2cm_pkg::PH_W3: begin
               if (bit_next >= i2cm_pkg::WRITE_CLOCKS) begin
                  phase_in = i2cm_pkg::PH_IDLE;
               end else begin
                  phase_in = i2cm_pkg::PH_W1;
                  wait_in  = half_wait;
               end
            end
            i2cm_pkg::PH_R1: begin phase_in = i2cm_pkg::PH_R2; wait_in = high_wait; end
            i2cm_pkg::PH_R2: begin
               if (bit_next >= i2cm_pkg::READ_BITS) begin
                  phase_in = i2cm_pkg::PH_A1;
                  wait_in  = half_wait;
               end else begin
                  phase_in = i2cm_pkg::PH_R1;
                  wait_in  = low_wait;
               end
            end
            i2cm_pkg::PH_A1: begin phase_in = i2cm_pkg::PH_A2; wait_in = half_wait; end
            i2cm_pkg::PH_A2: begin phase_in = i2cm_pkg::PH_A3; wait_in = high_wait; end
            default: phase_in = i2cm_pkg::PH_IDLE;
         endcase
      end
   end

   // pin levels and byte datapath
   always_comb begin
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      addr_pend_in = addr_pend_ff;
      read_flag_in = read_flag_ff;
      scl_in       = scl_ff;
      sda_lvl_in   = sda_lvl_ff;
      drive_in     = drive_ff;
      held_in      = held_ff;
      valid_in     = 1'b0;
      if (at_idle) begin
         case (tick_item.cmd)
            i2cm_pkg::CMD_START: begin
               addr_pend_in = 1'b1;
               read_flag_in = tick_item.start_read;
            end
            i2cm_pkg::CMD_WRITE: begin
               bit_in = '0;
               if (addr_pend_ff) begin
                  shift_in     = {tick_item.write_byte[6:0], read_flag_ff};
                  addr_pend_in = 1'b0;
                  read_flag_in = 1'b0;
               end else begin
                  shift_in = tick_item.write_byte;
               end
            end
            i2cm_pkg::CMD_READ: begin
               drive_in   = 1'b0;
               sda_lvl_in = !tick_item.send_ack;
               shift_in   = '0;
               bit_in     = '0;
            end
            default: ;
         endcase
      end else if (!counting) begin
         case (phase_ff)
            i2cm_pkg::PH_S1, i2cm_pkg::PH_P2, i2cm_pkg::PH_W2,
            i2cm_pkg::PH_R1, i2cm_pkg::PH_A2: scl_in = 1'b1;
            i2cm_pkg::PH_S2, i2cm_pkg::PH_P1: sda_lvl_in = 1'b0;
            i2cm_pkg::PH_S3: scl_in = 1'b0;
            i2cm_pkg::PH_P3: sda_lvl_in = 1'b1;
            i2cm_pkg::PH_W1: sda_lvl_in = shift_ff[7];
            i2cm_pkg::PH_W3: begin
               scl_in   = 1'b0;
               shift_in = {shift_ff[6:0], 1'b0};
               bit_in   = bit_next;
            end
            i2cm_pkg::PH_R2: begin
               scl_in   = 1'b0;
               shift_in = {shift_ff[6:0], tick_item.sda_in};
               bit_in   = bit_next;
            end
            i2cm_pkg::PH_A1: drive_in = 1'b1;
            i2cm_pkg::PH_A3: begin
               scl_in   = 1'b0;
               held_in  = shift_ff;
               valid_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_beat.scl_out    = scl_in;
      rsp_beat.sda_out    = drive_in ? sda_lvl_in : 1'b1;
      rsp_beat.sda_drive  = drive_in;
      rsp_beat.busy_res   = (phase_in != i2cm_pkg::PH_IDLE);
      rsp_beat.read_byte  = held_in;
      rsp_beat.read_valid = valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= i2cm_pkg::PH_IDLE;
         wait_ff      <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         addr_pend_ff <= 1'b0;
         read_flag_ff <= 1'b0;
         scl_ff       <= 1'b1;
         sda_lvl_ff   <= 1'b1;
         drive_ff     <= 1'b1;
         held_ff      <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         wait_ff      <= wait_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         addr_pend_ff <= addr_pend_in;
         read_flag_ff <= read_flag_in;
         scl_ff       <= scl_in;
         sda_lvl_ff   <= sda_lvl_in;
         drive_ff     <= drive_in;
         held_ff      <= held_in;
      end
   end

   a_idle_no_wait: assert property (@(posedge clock) disable iff (reset)
      phase_ff == i2cm_pkg::PH_IDLE |-> wait_ff == '0)
      else $error("wait count left over in idle");

   a_released_high: assert property (@(posedge clock) disable iff (reset)
      step |-> (rsp_beat.sda_drive || rsp_beat.sda_out))
      else $error("released SDA reported low");

   a_valid_ends_read: assert property (@(posedge clock) disable iff (reset)
      step && rsp_beat.read_valid |-> phase_ff == i2cm_pkg::PH_A3 && !rsp_beat.busy_res)
      else $error("read_valid outside read completion");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(wait_ff))
      else $error("engine moved without a tick");

endmodule

// ===== sv/i2cm_rsp_queue.sv =====
module i2cm_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              rsp_push,
   input  i2cm_pkg::rsp_type rsp_beat,
   output logic              rsp_full,
   output logic              empty,
   input  logic              pop,
   output i2cm_pkg::rsp_type rsp_item
);

   i2cm_pkg::rsp_type slot_ff [i2cm_pkg::QUEUE_DEPTH];
   logic [i2cm_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [i2cm_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [i2cm_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign rsp_full = (count_ff == i2cm_pkg::QCNT_W'(i2cm_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign rsp_item = slot_ff[rd_ptr_ff];
   assign do_push  = rsp_push && !rsp_full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= rsp_beat;
      end
   end

endmodule
